### sv/bos_pkg.sv
// Odd-even sort package: cell payload type, cell operation codes, FSM states and the ordering function.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package bos_pkg;

	localparam int unsigned VALUE_W = 32;

	// One slot of the sorting row; an empty slot orders after every held value.
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] data;
	} cell_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_LO,
		CELL_HI
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// True when a must sit after b in ascending order.
	function automatic logic after(input cell_t a, input cell_t b);
		after = (!a.valid && b.valid) || (a.valid && b.valid && (a.data > b.data));
	endfunction

endpackage

### sv/bos_if.sv
// Valid/ready channel interfaces for the odd-even sort block.
// Depends on bos_pkg for the value width.
interface bos_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [bos_pkg::VALUE_W-1:0] value;
	logic                               last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface bos_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bos_pkg::VALUE_W-1:0] sorted_value;
	logic                               final_res;

	modport source (output valid, output sorted_value, output final_res, input ready);
	modport sink (input valid, input sorted_value, input final_res, output ready);
endinterface

### sv/bos_cell.sv
// One slot of the sorting row: shifts with its neighbors or does half of a
// compare-exchange with one of them. Depends on bos_pkg.
module bos_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bos_pkg::cell_op_t op,
	input  bos_pkg::cell_t    left,
	input  bos_pkg::cell_t    right,
	output bos_pkg::cell_t    cell_q
);

	bos_pkg::cell_t nxt;

	always_comb begin
		unique case (op)
			bos_pkg::CELL_HOLD: nxt = cell_q;
			bos_pkg::CELL_SHR:  nxt = left;
			bos_pkg::CELL_SHL:  nxt = right;
			// lower slot of a pair keeps the smaller one
			bos_pkg::CELL_LO:   nxt = bos_pkg::after(cell_q, right) ? right : cell_q;
			bos_pkg::CELL_HI:   nxt = bos_pkg::after(left, cell_q) ? left : cell_q;
			default:            nxt = cell_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= nxt;
		end
	end

endmodule

### sv/block_odd_even_sort_top.sv
// Odd-even transposition sorter: a row of SIZE cells that loads a set, sorts it
// in place and shifts it out. Depends on bos_pkg, bos_if and bos_cell.
//
//  port   dir   beat payload              notes
//  item   sink  value, last               last ends the set; beats past SIZE dropped
//  res    src   sorted_value, final_res   ascending; final_res on the last beat
//
// Load shifts each accepted beat into cell 0 and the row right, then SIZE
// compare-exchange passes over the cell row (one pass per cycle, alternating pair
// parity), then one beat per cycle out of cell 0 while the row shifts left.
// item.ready is high only while loading; res stalls simply hold the row.
// Reset empties the row and returns to loading.
module block_odd_even_sort_top #(
	parameter int unsigned SIZE = 64
) (
	input logic       clk,
	input logic       arst_n,
	bos_in_if.sink    item,
	bos_out_if.source res
);

	localparam int unsigned CNT_W  = $clog2(SIZE + 1);
	localparam int unsigned PASS_W = $clog2(SIZE);

	bos_pkg::state_t   state_q, state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [PASS_W-1:0] pass_q;
	bos_pkg::cell_t    cells [SIZE];
	bos_pkg::cell_t    in_cell;

	logic item_acc, res_acc, room, pass_done, phase;

	assign item_acc  = item.valid && item.ready;
	assign res_acc   = res.valid && res.ready;
	assign room      = count_q != CNT_W'(SIZE);
	assign pass_done = pass_q == PASS_W'(SIZE - 1);
	assign phase     = pass_q[0];
	assign in_cell   = '{valid: 1'b1, data: item.value};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bos_pkg::ST_LOAD: if (item_acc && item.last) state_nxt = bos_pkg::ST_SORT;
			bos_pkg::ST_SORT: if (pass_done) state_nxt = bos_pkg::ST_EMIT;
			bos_pkg::ST_EMIT: if (res_acc && count_q == CNT_W'(1)) state_nxt = bos_pkg::ST_LOAD;
			default:          state_nxt = bos_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		item.ready       = state_q == bos_pkg::ST_LOAD;
		res.valid        = state_q == bos_pkg::ST_EMIT;
		res.sorted_value = cells[0].data;
		res.final_res    = count_q == CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bos_pkg::ST_LOAD;
			count_q <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == bos_pkg::ST_SORT) begin
				pass_q <= pass_q + PASS_W'(1);
			end else begin
				pass_q <= '0;
			end
			if (item_acc && room) begin
				count_q <= count_q + CNT_W'(1);
			end else if (res_acc) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	for (genvar g = 0; g < SIZE; g++) begin : g_cell
		localparam bit ODD    = (g % 2) == 1;
		localparam bit HAS_HI = g > 0;
		localparam bit HAS_LO = g < SIZE - 1;

		bos_pkg::cell_op_t op;
		bos_pkg::cell_t    left, right;

		if (g == 0) begin : g_left_in
			assign left = in_cell;
		end else begin : g_left_cell
			assign left = cells[g-1];
		end

		if (g == SIZE - 1) begin : g_right_end
			assign right = '0;
		end else begin : g_right_cell
			assign right = cells[g+1];
		end

		always_comb begin
			op = bos_pkg::CELL_HOLD;
			unique case (state_q)
				bos_pkg::ST_LOAD: if (item_acc && room) op = bos_pkg::CELL_SHR;
				bos_pkg::ST_EMIT: if (res_acc) op = bos_pkg::CELL_SHL;
				bos_pkg::ST_SORT: begin
					// pairs start at even slots on even passes, odd slots on odd passes
					if ((ODD == phase) && HAS_LO) begin
						op = bos_pkg::CELL_LO;
					end else if ((ODD != phase) && HAS_HI) begin
						op = bos_pkg::CELL_HI;
					end
				end
				default: op = bos_pkg::CELL_HOLD;
			endcase
		end

		bos_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (left),
			.right  (right),
			.cell_q (cells[g])
		);
	end

endmodule

### sv/bos_checker.sv
// Port-level checks for the odd-even sort block, bound to the top level.
// Depends on bos_pkg for the value width.
module bos_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               item_last,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [bos_pkg::VALUE_W-1:0] sorted_value,
	input logic                               final_res
);

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && res_valid))
		else $error("input ready while results are shown");

	// a set's end starts the sort: neither side moves next cycle
	a_sort_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_last) |=> (!item_ready && !res_valid))
		else $error("no sort gap after the set's last beat");

	// after the flagged beat the block is back to loading
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && final_res) |=> (item_ready && !res_valid))
		else $error("not loading after the final beat");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> ($stable(sorted_value) && $stable(final_res)))
		else $error("stalled result changed");

endmodule

bind block_odd_even_sort_top bos_checker u_bos_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_last    (item.last),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.sorted_value (res.sorted_value),
	.final_res    (res.final_res)
);
